@@ sv/cau_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cau_pkg
// widths, opcodes, pipeline payload types and shared helpers of the
// complex arithmetic unit
// ----------------------------------------------------------------------------
package cau_pkg;

    localparam int DW  = 32;
    localparam int FB  = 16;
    localparam int PW  = 2 * DW;
    localparam int SW  = PW + 2;
    localparam int NW  = PW + 1 + FB;
    localparam int QB  = DW + 1;
    localparam int HW  = NW - QB;
    localparam int LAT = 5 + QB;

    typedef enum logic [2:0] {
        OP_ADD  = 3'd0,
        OP_SUB  = 3'd1,
        OP_MUL  = 3'd2,
        OP_DIV  = 3'd3,
        OP_CONJ = 3'd4,
        OP_NEG  = 3'd5,
        OP_INV  = 3'd6,
        OP_NORM = 3'd7
    } t_op;

    typedef enum logic [1:0] {
        ST_OK  = 2'd0,
        ST_DZ  = 2'd1,
        ST_OVF = 2'd2
    } t_status;

    typedef struct packed {
        logic                 ovf;
        logic signed [DW-1:0] val;
    } t_sat;

    typedef struct packed {
        logic                 vld;
        t_op                  op;
        logic signed [DW-1:0] ar;
        logic signed [DW-1:0] ai;
        logic signed [DW-1:0] br;
        logic signed [DW-1:0] bi;
    } t_in;

    typedef struct packed {
        logic                 vld;
        t_op                  op;
        logic signed [DW-1:0] ar;
        logic signed [DW-1:0] ai;
        t_sat                 sr;
        t_sat                 si;
        logic signed [PW-1:0] p_rr;
        logic signed [PW-1:0] p_ii;
        logic signed [PW-1:0] p_ri;
        logic signed [PW-1:0] p_ir;
        logic signed [PW-1:0] d0;
        logic signed [PW-1:0] d1;
    } t_ms;

    typedef struct packed {
        logic                 vld;
        t_op                  op;
        t_sat                 sr;
        t_sat                 si;
        logic signed [SW-1:0] xr;
        logic signed [SW-1:0] xi;
        logic [PW-1:0]        den;
    } t_pa;

    typedef struct packed {
        logic          neg;
        logic          povf;
        logic [QB-1:0] nlo;
        logic [PW-1:0] rem;
        logic [QB-1:0] q;
    } t_lane;

    typedef struct packed {
        logic          vld;
        logic          is_div;
        logic          dz;
        t_sat          sr;
        t_sat          si;
        t_lane         lr;
        t_lane         li;
        logic [PW-1:0] den;
    } t_dv;

    function automatic t_sat sat(input logic signed [SW-1:0] x);
        logic signed [SW-1:0] hi;
        logic signed [SW-1:0] lo;
        t_sat                 r;
        hi = {{(SW-DW+1){1'b0}}, {(DW-1){1'b1}}};
        lo = ~hi;
        r.ovf = 1'b0;
        r.val = x[DW-1:0];
        if (x > hi) begin
            r.ovf = 1'b1;
            r.val = hi[DW-1:0];
        end else if (x < lo) begin
            r.ovf = 1'b1;
            r.val = lo[DW-1:0];
        end
        return r;
    endfunction

    function automatic t_lane div_bit(input t_lane l, input logic [PW-1:0] den);
        logic [PW:0] t;
        logic [PW:0] d;
        logic        ge;
        t_lane       r;
        t  = {l.rem, l.nlo[QB-1]};
        d  = {1'b0, den};
        ge = (t >= d);
        r       = l;
        r.rem   = ge ? PW'(t - d) : t[PW-1:0];
        r.nlo   = {l.nlo[QB-2:0], 1'b0};
        r.q     = {l.q[QB-2:0], ge};
        return r;
    endfunction

    function automatic t_sat fin(input t_lane l);
        logic [QB-1:0] lim;
        logic [QB-1:0] qn;
        logic          big;
        t_sat          r;
        lim   = {2'b01, {(DW-1){1'b0}}};
        big   = l.neg ? (l.q > lim) : (l.q >= lim);
        qn    = l.neg ? -l.q : l.q;
        r.ovf = l.povf | big;
        if (r.ovf) begin
            r.val = l.neg ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
        end else begin
            r.val = qn[DW-1:0];
        end
        return r;
    endfunction

endpackage

@@ sv/cau_mul_stage.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cau_mul_stage
// operand products and the add, subtract, conjugate and negate results
// ----------------------------------------------------------------------------
module cau_mul_stage import cau_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_in  i_d,
    output t_ms  o_d
);

    t_ms r_d;
    t_ms n_d;
    logic signed [DW-1:0] w_br;
    logic signed [DW-1:0] w_bi;
    logic signed [SW-1:0] w_xr;
    logic signed [SW-1:0] w_xi;

    always_comb begin
        // inverse and norm square a instead of using b
        if (i_d.op == OP_INV || i_d.op == OP_NORM) begin
            w_br = i_d.ar;
            w_bi = i_d.ai;
        end else begin
            w_br = i_d.br;
            w_bi = i_d.bi;
        end
        case (i_d.op)
            OP_ADD: begin
                w_xr = SW'(i_d.ar) + SW'(i_d.br);
                w_xi = SW'(i_d.ai) + SW'(i_d.bi);
            end
            OP_SUB: begin
                w_xr = SW'(i_d.ar) - SW'(i_d.br);
                w_xi = SW'(i_d.ai) - SW'(i_d.bi);
            end
            OP_CONJ: begin
                w_xr = SW'(i_d.ar);
                w_xi = -SW'(i_d.ai);
            end
            OP_NEG: begin
                w_xr = -SW'(i_d.ar);
                w_xi = -SW'(i_d.ai);
            end
            default: begin
                w_xr = '0;
                w_xi = '0;
            end
        endcase
        n_d      = r_d;
        n_d.vld  = i_d.vld;
        n_d.op   = i_d.op;
        n_d.ar   = i_d.ar;
        n_d.ai   = i_d.ai;
        n_d.sr   = sat(w_xr);
        n_d.si   = sat(w_xi);
        n_d.p_rr = i_d.ar * w_br;
        n_d.p_ii = i_d.ai * w_bi;
        n_d.p_ri = i_d.ar * w_bi;
        n_d.p_ir = i_d.ai * w_br;
        n_d.d0   = w_br * w_br;
        n_d.d1   = w_bi * w_bi;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d.vld <= 1'b0;
        end else begin
            r_d <= n_d;
        end
    end

    assign o_d = r_d;

endmodule

@@ sv/cau_prep.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cau_prep
// product sums, rounding of mul and norm, and divider setup
// ----------------------------------------------------------------------------
module cau_prep import cau_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_ms  i_d,
    output t_dv  o_d
);

    t_pa r_a;
    t_pa n_a;
    t_dv r_b;
    t_dv n_b;
    logic signed [SW-1:0] w_half;
    logic [SW-1:0]        w_mr;
    logic [SW-1:0]        w_mi;
    logic [NW-1:0]        w_nr;
    logic [NW-1:0]        w_ni;
    logic [HW-1:0]        w_hr;
    logic [HW-1:0]        w_hi;

    // sums of products
    always_comb begin
        n_a     = r_a;
        n_a.vld = i_d.vld;
        n_a.op  = i_d.op;
        n_a.sr  = i_d.sr;
        n_a.si  = i_d.si;
        n_a.den = PW'(i_d.d0) + PW'(i_d.d1);
        case (i_d.op)
            OP_MUL: begin
                n_a.xr = SW'(i_d.p_rr) - SW'(i_d.p_ii);
                n_a.xi = SW'(i_d.p_ri) + SW'(i_d.p_ir);
            end
            OP_DIV: begin
                n_a.xr = SW'(i_d.p_rr) + SW'(i_d.p_ii);
                n_a.xi = SW'(i_d.p_ir) - SW'(i_d.p_ri);
            end
            OP_INV: begin
                n_a.xr = SW'(i_d.ar) <<< FB;
                n_a.xi = -(SW'(i_d.ai) <<< FB);
            end
            OP_NORM: begin
                n_a.xr = SW'(i_d.p_rr) + SW'(i_d.p_ii);
                n_a.xi = '0;
            end
            default: begin
                n_a.xr = '0;
                n_a.xi = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a.vld <= 1'b0;
        end else begin
            r_a <= n_a;
        end
    end

    // rounding, magnitudes and quotient range check
    always_comb begin
        w_half = {{(SW-FB){1'b0}}, 1'b1, {(FB-1){1'b0}}};
        w_mr   = r_a.xr[SW-1] ? -r_a.xr : r_a.xr;
        w_mi   = r_a.xi[SW-1] ? -r_a.xi : r_a.xi;
        w_nr   = {w_mr[PW:0], {FB{1'b0}}};
        w_ni   = {w_mi[PW:0], {FB{1'b0}}};
        w_hr   = w_nr[NW-1:QB];
        w_hi   = w_ni[NW-1:QB];
        n_b        = r_b;
        n_b.vld    = r_a.vld;
        n_b.is_div = (r_a.op == OP_DIV) || (r_a.op == OP_INV);
        n_b.dz     = (r_a.den == '0);
        n_b.den    = r_a.den;
        if (r_a.op == OP_MUL || r_a.op == OP_NORM) begin
            n_b.sr = sat((r_a.xr + w_half) >>> FB);
            n_b.si = sat((r_a.xi + w_half) >>> FB);
        end else begin
            n_b.sr = r_a.sr;
            n_b.si = r_a.si;
        end
        n_b.lr.neg  = r_a.xr[SW-1];
        n_b.li.neg  = r_a.xi[SW-1];
        n_b.lr.povf = ({{(PW-HW){1'b0}}, w_hr} >= r_a.den);
        n_b.li.povf = ({{(PW-HW){1'b0}}, w_hi} >= r_a.den);
        n_b.lr.rem  = n_b.lr.povf ? '0 : {{(PW-HW){1'b0}}, w_hr};
        n_b.li.rem  = n_b.li.povf ? '0 : {{(PW-HW){1'b0}}, w_hi};
        n_b.lr.nlo  = w_nr[QB-1:0];
        n_b.li.nlo  = w_ni[QB-1:0];
        n_b.lr.q    = '0;
        n_b.li.q    = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b.vld <= 1'b0;
        end else begin
            r_b <= n_b;
        end
    end

    assign o_d = r_b;

endmodule

@@ sv/cau_div_step.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cau_div_step
// one restoring division bit for the real and imaginary quotients
// ----------------------------------------------------------------------------
module cau_div_step import cau_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_dv  i_d,
    output t_dv  o_d
);

    t_dv r_d;
    t_dv n_d;

    always_comb begin
        n_d    = i_d;
        n_d.lr = div_bit(i_d.lr, i_d.den);
        n_d.li = div_bit(i_d.li, i_d.den);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d.vld <= 1'b0;
        end else begin
            r_d <= n_d;
        end
    end

    assign o_d = r_d;

endmodule

@@ sv/complex_arith_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// complex_arith_unit
// pipelined complex add, sub, mul, div, conj, neg, inverse and norm
// every opcode runs through input, product, two setup, 33 divider and one
// output stage from the start edge to the edge that takes the result
// throughput: one request per cycle; the divider stages only add latency
// busy stays low; results cannot be held off
// synchronous active-low reset clears the pipeline valid bits only
// ----------------------------------------------------------------------------
module complex_arith_unit import cau_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [2:0]           i_opcode,
    input  logic signed [DW-1:0] i_a_real,
    input  logic signed [DW-1:0] i_a_imag,
    input  logic signed [DW-1:0] i_b_real,
    input  logic signed [DW-1:0] i_b_imag,
    output logic                 o_valid,
    output logic signed [DW-1:0] o_out_real,
    output logic signed [DW-1:0] o_out_imag,
    output logic [1:0]           o_status
);

    t_in  r_in;
    t_in  n_in;
    t_ms  w_ms;
    t_dv  w_dv [QB+1];
    logic                 r_valid;
    logic signed [DW-1:0] r_real;
    logic signed [DW-1:0] r_imag;
    t_status              r_status;
    t_status              n_status;
    logic signed [DW-1:0] n_real;
    logic signed [DW-1:0] n_imag;
    t_sat                 w_qr;
    t_sat                 w_qi;

    assign busy = 1'b0;

    always_comb begin
        n_in.vld = start & ~busy;
        n_in.op  = t_op'(i_opcode);
        n_in.ar  = i_a_real;
        n_in.ai  = i_a_imag;
        n_in.br  = i_b_real;
        n_in.bi  = i_b_imag;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in.vld <= 1'b0;
        end else begin
            r_in <= n_in;
        end
    end

    cau_mul_stage u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_d     (r_in),
        .o_d     (w_ms)
    );

    cau_prep u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_d     (w_ms),
        .o_d     (w_dv[0])
    );

    for (genvar k = 0; k < QB; k++) begin : g_div
        cau_div_step u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_d     (w_dv[k]),
            .o_d     (w_dv[k+1])
        );
    end

    always_comb begin
        w_qr = fin(w_dv[QB].lr);
        w_qi = fin(w_dv[QB].li);
        if (w_dv[QB].is_div) begin
            if (w_dv[QB].dz) begin
                n_real   = '0;
                n_imag   = '0;
                n_status = ST_DZ;
            end else begin
                n_real   = w_qr.val;
                n_imag   = w_qi.val;
                n_status = (w_qr.ovf | w_qi.ovf) ? ST_OVF : ST_OK;
            end
        end else begin
            n_real   = w_dv[QB].sr.val;
            n_imag   = w_dv[QB].si.val;
            n_status = (w_dv[QB].sr.ovf | w_dv[QB].si.ovf) ? ST_OVF : ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= w_dv[QB].vld;
        end
        r_real   <= n_real;
        r_imag   <= n_imag;
        r_status <= n_status;
    end

    assign o_valid    = r_valid;
    assign o_out_real = r_real;
    assign o_out_imag = r_imag;
    assign o_status   = r_status;

endmodule

@@ sv/cau_check.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cau_check
// port-level checks of the complex arithmetic unit
// ----------------------------------------------------------------------------
module cau_check import cau_pkg::*; (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 start,
    input logic                 busy,
    input logic [2:0]           i_opcode,
    input logic signed [DW-1:0] i_a_real,
    input logic signed [DW-1:0] i_a_imag,
    input logic signed [DW-1:0] i_b_real,
    input logic signed [DW-1:0] i_b_imag,
    input logic                 o_valid,
    input logic signed [DW-1:0] o_out_real,
    input logic signed [DW-1:0] o_out_imag,
    input logic [1:0]           o_status
);

    a_busy_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy)
        else $error("busy raised");

    a_latency: assert property (@(posedge i_clk)
        ##LAT (o_valid == ($past(start & ~busy & i_rst_n, LAT) &&
                           $past(i_rst_n, LAT - 1)) || !i_rst_n ||
               !$past(i_rst_n, 1)))
        else $error("result strobe does not match request");

    a_dz_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == ST_DZ) |-> (o_out_real == '0 && o_out_imag == '0))
        else $error("divide by zero with nonzero result");

    a_dz_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ##LAT (o_valid && o_status == ST_DZ) |->
            ($past(i_opcode, LAT) == OP_DIV || $past(i_opcode, LAT) == OP_INV))
        else $error("divide by zero on non-dividing op");

    a_norm_imag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ##LAT (o_valid && $past(i_opcode, LAT) == OP_NORM) |-> (o_out_imag == '0))
        else $error("norm with nonzero imaginary part");

endmodule

bind complex_arith_unit cau_check u_cau_check (.*);
